// File: rtl/core/ihtr_pkg.sv
// Package with the phase type and constants of the sensor measurement reader.
`timescale 1ns / 1ps

package ihtr_pkg;

  // Sequencer phases of one measurement transaction.
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_PROBE,
    PH_WR_PROBE,
    PH_SP_PROBE,
    PH_ST_CMD,
    PH_WR_CADDR,
    PH_WR_CMD,
    PH_ST_POLL,
    PH_WR_POLL,
    PH_RD_MSB,
    PH_RD_LSB,
    PH_RD_CHK,
    PH_SP_OK,
    PH_SP_FAIL
  } phase_t;

  // Opcodes of an input item.
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_TEMP = 2'd1;
  localparam logic [1:0] OP_HUM  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_DEV_ADDR  = 1'b0;
  localparam logic REG_MAX_POLLS = 1'b1;

  localparam int CFG_DATA_W = 16;

  localparam logic [6:0]  DEV_ADDR_RST  = 7'd64;
  localparam logic [15:0] MAX_POLLS_RST = 16'hFFFF;

  // Command bytes.
  localparam logic [7:0] CMD_TEMP = 8'hF3;
  localparam logic [7:0] CMD_HUM  = 8'hF5;

  // Fixed-point: value = raw*slope/65536 - offset; slope, offset in hundredths.
  localparam logic [14:0] TEMP_SLOPE = 15'd17572;
  localparam logic [14:0] HUM_SLOPE  = 15'd12500;
  localparam logic [12:0] TEMP_OFS   = 13'd4685;
  localparam logic [12:0] HUM_OFS    = 13'd600;

endpackage

// File: rtl/core/ihtr_in_if.sv
// Input channel: one bus timing slot with an optional start request.
`timescale 1ns / 1ps

interface ihtr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       sda_in;

  modport source (output valid, output opcode, output sda_in, input ready);
  modport sink   (input valid, input opcode, input sda_in, output ready);
endinterface

// File: rtl/core/ihtr_out_if.sv
// Result channel: bus drive levels and status for one timing slot.
`timescale 1ns / 1ps

interface ihtr_out_if;
  logic              valid;
  logic              ready;
  logic              scl;
  logic              sda_out;
  logic              sda_oe;
  logic              busy_res;
  logic              done_res;
  logic              fail;
  logic signed [14:0] value;

  modport source (output valid, output scl, output sda_out, output sda_oe,
                  output busy_res, output done_res, output fail, output value,
                  input ready);
  modport sink   (input valid, input scl, input sda_out, input sda_oe,
                  input busy_res, input done_res, input fail, input value,
                  output ready);
endinterface

// File: rtl/core/i2c_humidity_temp_sensor_reader_top.sv
// Bit-level I2C master that runs one temperature or humidity measurement.
`timescale 1ns / 1ps

// Each transfer on the input channel is one bus timing slot; the block answers it with
// exactly one result carrying the SCL/SDA drive for that slot plus busy, done, fail and
// the scaled value. The sequencer next-state logic and the scaling multiplier are
// combinational between the input transfer and the output register, so one slot is
// accepted every clock unless a waiting result holds it off, and its result appears
// in the clock after. A new slot can enter in the same clock as the previous result is
// taken; while a result waits, the input is held off.
// Address writes apply at the next address byte; poll-limit writes at the next poll.
module i2c_humidity_temp_sensor_reader_top (
  input  logic                           clk,
  input  logic                           rst_n,
  ihtr_in_if.sink                        in_chan,
  ihtr_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [ihtr_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [6:0]  dev_addr_r;
  logic [15:0] max_polls_r;

  // Sequencer state.
  ihtr_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  slot_r, slot_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  msb_r, msb_nxt;
  logic [7:0]  lsb_r, lsb_nxt;
  logic [15:0] poll_r, poll_nxt;
  logic        kind_r, kind_nxt;

  // Slot results.
  logic        scl_c, sdo_c, oe_c, busy_c, done_c, fail_c;
  logic [14:0] value_c;

  logic        out_valid_r;
  logic        scl_r, sdo_r, oe_r, busy_r, done_r, fail_r;
  logic [14:0] value_r;

  logic        accept;
  logic        last;
  logic        in_byte;
  logic        ack;
  logic [7:0]  wr_byte;
  logic [16:0] poll_inc;

  // Scaling datapath.
  logic [15:0]        raw;
  logic [14:0]        slope;
  logic [12:0]        ofs;
  logic [30:0]        product;
  logic signed [32:0] numer;
  logic signed [16:0] quot;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign last     = slot_r[1];
  assign in_byte  = !bit_r[3];
  assign wr_byte  = {dev_addr_r, 1'b0};
  assign ack      = !shift_r[0];
  assign poll_inc = {1'b0, poll_r} + 17'd1;

  // Truncation toward zero: the offset term has zero low bits, so the fraction is
  // the low half of the product.
  assign raw     = {msb_r, lsb_r[7:2], 2'b00};
  assign slope   = kind_r ? ihtr_pkg::HUM_SLOPE : ihtr_pkg::TEMP_SLOPE;
  assign ofs     = kind_r ? ihtr_pkg::HUM_OFS : ihtr_pkg::TEMP_OFS;
  assign product = raw * slope;
  assign numer   = $signed({2'b00, product}) - $signed({4'b0000, ofs, 16'h0000});
  assign quot    = numer[32:16] + ((numer[32] && (product[15:0] != 16'h0000)) ? 17'sd1
                                                                           : 17'sd0);

  // Next-state logic.
  always_comb begin
    phase_nxt = phase_r;
    slot_nxt  = slot_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    msb_nxt   = msb_r;
    lsb_nxt   = lsb_r;
    poll_nxt  = poll_r;
    kind_nxt  = kind_r;

    case (phase_r)
      ihtr_pkg::PH_ST_PROBE, ihtr_pkg::PH_ST_CMD, ihtr_pkg::PH_ST_POLL: begin
        if (!last) begin
          slot_nxt = slot_r + 2'd1;
        end else begin
          slot_nxt = 2'd0;
          bit_nxt  = 4'd0;
          if (phase_r == ihtr_pkg::PH_ST_PROBE) begin
            phase_nxt = ihtr_pkg::PH_WR_PROBE;
            shift_nxt = wr_byte;
          end else if (phase_r == ihtr_pkg::PH_ST_CMD) begin
            phase_nxt = ihtr_pkg::PH_WR_CADDR;
            shift_nxt = wr_byte;
          end else begin
            phase_nxt = ihtr_pkg::PH_WR_POLL;
            shift_nxt = wr_byte | 8'h01;
          end
        end
      end

      ihtr_pkg::PH_WR_PROBE, ihtr_pkg::PH_WR_CADDR, ihtr_pkg::PH_WR_CMD,
      ihtr_pkg::PH_WR_POLL: begin
        if (!in_byte && slot_r == 2'd1) begin
          shift_nxt = {7'd0, in_chan.sda_in};
        end
        if (!last) begin
          slot_nxt = slot_r + 2'd1;
        end else if (in_byte) begin
          slot_nxt  = 2'd0;
          shift_nxt = {shift_r[6:0], 1'b0};
          bit_nxt   = bit_r + 4'd1;
        end else begin
          slot_nxt  = 2'd0;
          bit_nxt   = 4'd0;
          shift_nxt = 8'd0;
          case (phase_r)
            ihtr_pkg::PH_WR_PROBE: begin
              phase_nxt = ack ? ihtr_pkg::PH_SP_PROBE : ihtr_pkg::PH_SP_FAIL;
            end
            ihtr_pkg::PH_WR_CADDR: begin
              if (ack) begin
                phase_nxt = ihtr_pkg::PH_WR_CMD;
                shift_nxt = kind_r ? ihtr_pkg::CMD_HUM : ihtr_pkg::CMD_TEMP;
              end else begin
                phase_nxt = ihtr_pkg::PH_SP_FAIL;
              end
            end
            ihtr_pkg::PH_WR_CMD: begin
              phase_nxt = ack ? ihtr_pkg::PH_ST_POLL : ihtr_pkg::PH_SP_FAIL;
            end
            default: begin
              if (ack) begin
                phase_nxt = ihtr_pkg::PH_RD_MSB;
              end else begin
                // A NACKed poll counts toward the limit; a limit of zero acts as one.
                poll_nxt  = poll_inc[15:0];
                phase_nxt = (poll_inc >= {1'b0, max_polls_r}) ? ihtr_pkg::PH_SP_FAIL
                                                              : ihtr_pkg::PH_ST_POLL;
              end
            end
          endcase
        end
      end

      ihtr_pkg::PH_RD_MSB, ihtr_pkg::PH_RD_LSB, ihtr_pkg::PH_RD_CHK: begin
        if (in_byte && slot_r == 2'd1) begin
          shift_nxt = {shift_r[6:0], in_chan.sda_in};
        end
        if (!last) begin
          slot_nxt = slot_r + 2'd1;
        end else if (in_byte) begin
          slot_nxt = 2'd0;
          bit_nxt  = bit_r + 4'd1;
        end else begin
          slot_nxt  = 2'd0;
          bit_nxt   = 4'd0;
          shift_nxt = 8'd0;
          if (phase_r == ihtr_pkg::PH_RD_MSB) begin
            msb_nxt   = shift_r;
            phase_nxt = (shift_r == 8'd0) ? ihtr_pkg::PH_SP_FAIL : ihtr_pkg::PH_RD_LSB;
          end else if (phase_r == ihtr_pkg::PH_RD_LSB) begin
            lsb_nxt   = shift_r;
            phase_nxt = ihtr_pkg::PH_RD_CHK;
          end else begin
            phase_nxt = ihtr_pkg::PH_SP_OK;
          end
        end
      end

      ihtr_pkg::PH_SP_PROBE, ihtr_pkg::PH_SP_OK, ihtr_pkg::PH_SP_FAIL: begin
        if (!last) begin
          slot_nxt = slot_r + 2'd1;
        end else begin
          slot_nxt  = 2'd0;
          bit_nxt   = 4'd0;
          shift_nxt = 8'd0;
          phase_nxt = (phase_r == ihtr_pkg::PH_SP_PROBE) ? ihtr_pkg::PH_ST_CMD
                                                         : ihtr_pkg::PH_IDLE;
        end
      end

      default: begin
        slot_nxt  = 2'd0;
        bit_nxt   = 4'd0;
        shift_nxt = 8'd0;
        if (in_chan.opcode == ihtr_pkg::OP_TEMP || in_chan.opcode == ihtr_pkg::OP_HUM) begin
          kind_nxt  = (in_chan.opcode == ihtr_pkg::OP_HUM);
          poll_nxt  = 16'd0;
          phase_nxt = ihtr_pkg::PH_ST_PROBE;
        end else begin
          phase_nxt = ihtr_pkg::PH_IDLE;
        end
      end
    endcase
  end

  // Bus drive and status for the current slot.
  always_comb begin
    scl_c   = 1'b1;
    sdo_c   = 1'b1;
    oe_c    = 1'b1;
    busy_c  = 1'b1;
    done_c  = 1'b0;
    fail_c  = 1'b0;
    value_c = 15'd0;

    case (phase_r)
      ihtr_pkg::PH_ST_PROBE, ihtr_pkg::PH_ST_CMD, ihtr_pkg::PH_ST_POLL: begin
        scl_c = !last;
        sdo_c = (slot_r == 2'd0);
      end

      ihtr_pkg::PH_WR_PROBE, ihtr_pkg::PH_WR_CADDR, ihtr_pkg::PH_WR_CMD,
      ihtr_pkg::PH_WR_POLL: begin
        scl_c = (slot_r == 2'd1);
        if (in_byte) begin
          sdo_c = shift_r[7];
        end else begin
          oe_c  = 1'b0;
          sdo_c = 1'b0;
        end
      end

      ihtr_pkg::PH_RD_MSB, ihtr_pkg::PH_RD_LSB, ihtr_pkg::PH_RD_CHK: begin
        scl_c = (slot_r == 2'd1);
        sdo_c = 1'b0;
        if (in_byte) begin
          oe_c = 1'b0;
        end else begin
          // The checksum and a zero MSB are answered with NACK.
          oe_c = (phase_r != ihtr_pkg::PH_RD_CHK) &&
                 !(phase_r == ihtr_pkg::PH_RD_MSB && shift_r == 8'd0);
        end
      end

      ihtr_pkg::PH_SP_PROBE, ihtr_pkg::PH_SP_OK, ihtr_pkg::PH_SP_FAIL: begin
        scl_c = (slot_r != 2'd0);
        sdo_c = last;
        if (last && phase_r != ihtr_pkg::PH_SP_PROBE) begin
          done_c = 1'b1;
          if (phase_r == ihtr_pkg::PH_SP_FAIL) begin
            fail_c = 1'b1;
          end else begin
            value_c = quot[14:0];
          end
        end
      end

      default: begin
        busy_c = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= ihtr_pkg::DEV_ADDR_RST;
      max_polls_r <= ihtr_pkg::MAX_POLLS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ihtr_pkg::REG_DEV_ADDR:  dev_addr_r  <= cfg_data[6:0];
        ihtr_pkg::REG_MAX_POLLS: max_polls_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer state advances once per accepted slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ihtr_pkg::PH_IDLE;
      slot_r  <= 2'd0;
      bit_r   <= 4'd0;
      shift_r <= 8'd0;
      msb_r   <= 8'd0;
      lsb_r   <= 8'd0;
      poll_r  <= 16'd0;
      kind_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      slot_r  <= slot_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      msb_r   <= msb_nxt;
      lsb_r   <= lsb_nxt;
      poll_r  <= poll_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scl_r   <= scl_c;
      sdo_r   <= sdo_c;
      oe_r    <= oe_c;
      busy_r  <= busy_c;
      done_r  <= done_c;
      fail_r  <= fail_c;
      value_r <= value_c;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.scl      = scl_r;
  assign out_chan.sda_out  = sdo_r;
  assign out_chan.sda_oe   = oe_r;
  assign out_chan.busy_res = busy_r;
  assign out_chan.done_res = done_r;
  assign out_chan.fail     = fail_r;
  assign out_chan.value    = $signed(value_r);

endmodule
